@@ rtl/gradient_glow_pixel_generator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gradient glow pixel generator
// Short forms of the concurrent assertions used at the end of the core.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_GLOW_PIXEL_GENERATOR_CORE_MACROS_SVH
`define GRADIENT_GLOW_PIXEL_GENERATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GGPG_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GGPG_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ggpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient glow pixel generator package
// Widths, types, colour constants and register codes shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package ggpg_pkg;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int MAX_DIM = 4096;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = FRAC_W + 1;

  // Square root unit: radicand width and one result bit per stage.
  localparam int ISQRT_W     = 58;
  localparam int ISQRT_STEPS = ISQRT_W / 2;
  localparam int ROOT_W      = ISQRT_STEPS;

  // Fraction divider: operand width, one set-up stage and one quotient bit per stage.
  localparam int DIV_W   = 29;
  localparam int DIV_LAT = FRAC_W + 1;

  typedef logic [ISQRT_W-1:0] sq_val_t;
  typedef logic [DIV_W-1:0]   div_opd_t;
  typedef logic [Q_W-1:0]     q_t;

  typedef struct packed {
    q_t r;
    q_t g;
    q_t b;
  } rgb_t;

  localparam q_t Q_ONE = q_t'(1 << FRAC_W);

  // Configuration register codes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd1080;

  // Corner colours, Q16: top-left, top-right, bottom-left, bottom-right.
  localparam q_t TL_R = 17'd3276;
  localparam q_t TR_R = 17'd7864;
  localparam q_t BL_R = 17'd5242;
  localparam q_t BR_R = 17'd14417;
  localparam q_t TL_G = 17'd3276;
  localparam q_t TR_G = 17'd2621;
  localparam q_t BL_G = 17'd6553;
  localparam q_t BR_G = 17'd3932;
  localparam q_t TL_B = 17'd13107;
  localparam q_t TR_B = 17'd16384;
  localparam q_t BL_B = 17'd19660;
  localparam q_t BR_B = 17'd18350;

  // Glow centres as fractions of the image size, Q16.
  localparam logic [15:0] CX1 = 16'd26214;
  localparam logic [15:0] CY1 = 16'd22937;
  localparam logic [15:0] CX2 = 16'd49152;
  localparam logic [15:0] CY2 = 16'd45875;
  localparam logic [15:0] R2_SCALE = 16'd39321;

  // Glow strengths and per-channel highlight weights, Q16.
  localparam logic [15:0] K1 = 16'd9830;
  localparam logic [15:0] K2 = 16'd6553;
  localparam logic [15:0] HL1_R = 16'd19660;
  localparam logic [15:0] HL1_G = 16'd9830;
  localparam logic [15:0] HL1_B = 16'd26214;
  localparam logic [15:0] HL2_R = 16'd6553;
  localparam logic [15:0] HL2_G = 16'd13107;
  localparam logic [15:0] HL2_B = 16'd29491;

  localparam logic [7:0] BYTE_SCALE = 8'd255;
  localparam logic [7:0] ALPHA      = 8'hFF;

endpackage

`default_nettype wire

@@ rtl/ggpg_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 58-bit radicand, one result bit resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ggpg_isqrt (
  input  wire                            clk,
  input  wire ggpg_pkg::sq_val_t         din,
  output logic [ggpg_pkg::ROOT_W-1:0]    root
);

  localparam int W     = ggpg_pkg::ISQRT_W;
  localparam int STEPS = ggpg_pkg::ISQRT_STEPS;

  ggpg_pkg::sq_val_t v_q  [STEPS];
  ggpg_pkg::sq_val_t r_q  [STEPS];
  ggpg_pkg::sq_val_t v_in [STEPS];
  ggpg_pkg::sq_val_t r_in [STEPS];
  ggpg_pkg::sq_val_t v_nx [STEPS];
  ggpg_pkg::sq_val_t r_nx [STEPS];

  always_comb begin
    ggpg_pkg::sq_val_t bit_c;
    logic [W:0] trial;
    v_in[0] = din;
    r_in[0] = '0;
    for (int i = 1; i < STEPS; i++) begin
      v_in[i] = v_q[i-1];
      r_in[i] = r_q[i-1];
    end
    // Each stage tries the next pair of radicand bits against the partial root.
    for (int i = 0; i < STEPS; i++) begin
      bit_c = ggpg_pkg::sq_val_t'(1) << (W - 2 - 2 * i);
      trial = {1'b0, r_in[i]} + {1'b0, bit_c};
      if ({1'b0, v_in[i]} >= trial) begin
        v_nx[i] = v_in[i] - trial[W-1:0];
        r_nx[i] = (r_in[i] >> 1) + bit_c;
      end else begin
        v_nx[i] = v_in[i];
        r_nx[i] = r_in[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_q <= v_nx;
    r_q <= r_nx;
  end

  assign root = r_q[STEPS-1][ggpg_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/ggpg_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Gives min(1.0, num / den) in Q16; after a set-up stage, one quotient bit is resolved per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ggpg_div (
  input  wire                      clk,
  input  wire ggpg_pkg::div_opd_t  num,
  input  wire ggpg_pkg::div_opd_t  den,
  output ggpg_pkg::q_t             quo
);

  localparam int N  = ggpg_pkg::DIV_LAT;
  localparam int W  = ggpg_pkg::DIV_W;
  localparam int FW = ggpg_pkg::FRAC_W;

  ggpg_pkg::div_opd_t rem_q  [N];
  ggpg_pkg::div_opd_t den_q  [N];
  ggpg_pkg::div_opd_t rem_nx [N];
  ggpg_pkg::div_opd_t den_nx [N];
  logic [FW-1:0]      q_q    [N];
  logic [FW-1:0]      q_nx   [N];
  logic [N-1:0]       sat_q;
  logic [N-1:0]       sat_nx;

  always_comb begin
    logic [W:0] rem2;
    // When the numerator is not below the divisor the fraction saturates at
    // one, which also covers a zero divisor.
    rem_nx[0] = num;
    den_nx[0] = den;
    sat_nx[0] = (num >= den);
    q_nx[0]   = '0;
    for (int k = 1; k < N; k++) begin
      rem2      = {rem_q[k-1], 1'b0};
      den_nx[k] = den_q[k-1];
      sat_nx[k] = sat_q[k-1];
      if (rem2 >= {1'b0, den_q[k-1]}) begin
        rem_nx[k] = rem2[W-1:0] - den_q[k-1];
        q_nx[k]   = {q_q[k-1][FW-2:0], 1'b1};
      end else begin
        rem_nx[k] = rem2[W-1:0];
        q_nx[k]   = {q_q[k-1][FW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_q <= rem_nx;
    den_q <= den_nx;
    q_q   <= q_nx;
    sat_q <= sat_nx;
  end

  assign quo = sat_q[N-1] ? ggpg_pkg::Q_ONE : {1'b0, q_q[N-1]};

endmodule

`default_nettype wire

@@ rtl/gradient_glow_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// Gradient glow pixel generator core
// One pixel is taken every cycle; done is raised together with that pixel's pixel_argb.
// The depth is set by the 29-stage square root and the 17-stage divider.
// Reset clears the pipeline valid bits and loads a 1920 by 1080 image size.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gradient_glow_pixel_generator_core_macros.svh"

module gradient_glow_pixel_generator_core (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  output logic                                 busy,
  input  wire [ggpg_pkg::COORD_W-1:0]          x,
  input  wire [ggpg_pkg::COORD_W-1:0]          y,
  input  wire                                  write_enable,
  input  wire [ggpg_pkg::CFG_IDX_W-1:0]        write_index,
  input  wire [ggpg_pkg::DIM_W-1:0]            write_data,
  output logic                                 done,
  output logic [31:0]                          pixel_argb
);

  localparam int DIST_STAGE  = 4 + ggpg_pkg::ISQRT_STEPS;
  localparam int RATIO_STAGE = DIST_STAGE + ggpg_pkg::DIV_LAT;
  localparam int GLOW_STAGE  = RATIO_STAGE + 4;
  localparam int FRAC_STAGE  = ggpg_pkg::DIV_LAT;
  localparam int BASE_STAGE  = FRAC_STAGE + 3;
  localparam int COL_DELAY   = GLOW_STAGE - BASE_STAGE;
  localparam int OUT_STAGE   = GLOW_STAGE + 3;
  localparam int LAT         = OUT_STAGE + 1;

  typedef logic [ggpg_pkg::DIM_W-1:0] dim_t;
  typedef logic [27:0]                pos_t;

  function automatic dim_t dim_clamp(input dim_t v);
    if (v == '0) begin
      dim_clamp = dim_t'(1);
    end else if (v > dim_t'(ggpg_pkg::MAX_DIM)) begin
      dim_clamp = dim_t'(ggpg_pkg::MAX_DIM);
    end else begin
      dim_clamp = v;
    end
  endfunction

  function automatic pos_t absd(input pos_t a, input pos_t b);
    absd = (a >= b) ? a - b : b - a;
  endfunction

  function automatic ggpg_pkg::q_t lerp_q(input ggpg_pkg::q_t a, input ggpg_pkg::q_t b,
                                          input ggpg_pkg::q_t t);
    logic [33:0] p;
    if (b >= a) begin
      p = 34'(b - a) * 34'(t);
      lerp_q = a + p[32:16];
    end else begin
      p = 34'(a - b) * 34'(t);
      lerp_q = a - p[32:16];
    end
  endfunction

  function automatic ggpg_pkg::q_t lerp_fin(input ggpg_pkg::q_t a, input ggpg_pkg::q_t mag,
                                            input logic up, input ggpg_pkg::q_t t);
    logic [33:0] p;
    p = 34'(mag) * 34'(t);
    lerp_fin = up ? a + p[32:16] : a - p[32:16];
  endfunction

  function automatic ggpg_pkg::q_t add_glow(input ggpg_pkg::q_t c, input logic [15:0] hl,
                                            input logic [15:0] gl);
    logic [31:0] p;
    logic [17:0] s;
    p = 32'(hl) * 32'(gl);
    s = 18'(c) + 18'(p[31:16]);
    add_glow = (s > 18'(ggpg_pkg::Q_ONE)) ? ggpg_pkg::Q_ONE : s[16:0];
  endfunction

  function automatic logic [7:0] to_byte(input ggpg_pkg::q_t c);
    logic [24:0] p;
    p = 25'(c) * 25'(ggpg_pkg::BYTE_SCALE);
    to_byte = p[23:16];
  endfunction

  logic                accept;
  logic [OUT_STAGE:0]  vld;
  dim_t                img_width;
  dim_t                img_height;

  // Stage 0 to 4: coordinates, glow offsets and squared distances.
  logic [ggpg_pkg::COORD_W-1:0] x0, y0;
  dim_t                w0, h0;
  pos_t                px1, py1, c1x1, c1y1, c2x1, c2y1;
  logic [24:0]         wsq1, hsq1;
  pos_t                dx1_2, dy1_2, dx2_2, dy2_2;
  logic [25:0]         rs2;
  logic [55:0]         sqx1_3, sqy1_3, sqx2_3, sqy2_3;
  logic [56:0]         sum1_4, sum2_4;

  // Radii and distances.
  logic [ggpg_pkg::ROOT_W-1:0] root_rad, dist1, dist2;
  logic [27:0]         r1_32;
  logic [43:0]         r2m_32;
  logic [27:0]         rad1, rad2;

  // Glow chain.
  ggpg_pkg::q_t        ratio1, ratio2;
  ggpg_pkg::q_t        g1_a, g2_a, g1_b, g2_b, gg1, gg2, g3_1, g3_2;
  logic [15:0]         glow1, glow2, glow2_d;

  // Colour chain.
  ggpg_pkg::div_opd_t  fx_num, fx_den, fy_num, fy_den;
  ggpg_pkg::q_t        fx, fy, fy18, fy19;
  ggpg_pkg::rgb_t      top18, bot18, a19, mag19, base20, c55, c56;
  logic [2:0]          up19;
  ggpg_pkg::rgb_t      col_d [COL_DELAY];

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign done   = vld[OUT_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= ggpg_pkg::WIDTH_RST;
      img_height <= ggpg_pkg::HEIGHT_RST;
    end else if (write_enable) begin
      unique case (write_index)
        ggpg_pkg::REG_WIDTH:  img_width  <= write_data;
        ggpg_pkg::REG_HEIGHT: img_height <= write_data;
        default:              img_width  <= img_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[OUT_STAGE-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    x0 <= x;
    y0 <= y;
    w0 <= dim_clamp(img_width);
    h0 <= dim_clamp(img_height);

    px1  <= {x0, 16'b0};
    py1  <= {y0, 16'b0};
    c1x1 <= pos_t'(w0) * pos_t'(ggpg_pkg::CX1);
    c1y1 <= pos_t'(h0) * pos_t'(ggpg_pkg::CY1);
    c2x1 <= pos_t'(w0) * pos_t'(ggpg_pkg::CX2);
    c2y1 <= pos_t'(h0) * pos_t'(ggpg_pkg::CY2);
    wsq1 <= 25'(w0) * 25'(w0);
    hsq1 <= 25'(h0) * 25'(h0);

    dx1_2 <= absd(px1, c1x1);
    dy1_2 <= absd(py1, c1y1);
    dx2_2 <= absd(px1, c2x1);
    dy2_2 <= absd(py1, c2y1);
    rs2   <= 26'(wsq1) + 26'(hsq1);

    sqx1_3 <= 56'(dx1_2) * 56'(dx1_2);
    sqy1_3 <= 56'(dy1_2) * 56'(dy1_2);
    sqx2_3 <= 56'(dx2_2) * 56'(dx2_2);
    sqy2_3 <= 56'(dy2_2) * 56'(dy2_2);

    sum1_4 <= 57'(sqx1_3) + 57'(sqy1_3);
    sum2_4 <= 57'(sqx2_3) + 57'(sqy2_3);
  end

  // The main radius is half the root of (w*w + h*h) taken in Q16.
  ggpg_isqrt u_isqrt_rad (
    .clk  (clk),
    .din  ({rs2, 32'b0}),
    .root (root_rad)
  );

  ggpg_isqrt u_isqrt_d1 (
    .clk  (clk),
    .din  ({1'b0, sum1_4}),
    .root (dist1)
  );

  ggpg_isqrt u_isqrt_d2 (
    .clk  (clk),
    .din  ({1'b0, sum2_4}),
    .root (dist2)
  );

  always_ff @(posedge clk) begin
    r1_32  <= root_rad[ggpg_pkg::ROOT_W-1:1];
    r2m_32 <= 44'(root_rad[ggpg_pkg::ROOT_W-1:1]) * 44'(ggpg_pkg::R2_SCALE);
    rad1   <= r1_32;
    rad2   <= r2m_32[43:16];
  end

  // A zero radius saturates the ratio, so that glow comes out as zero.
  ggpg_div u_div_ratio1 (
    .clk (clk),
    .num (dist1),
    .den ({1'b0, rad1}),
    .quo (ratio1)
  );

  ggpg_div u_div_ratio2 (
    .clk (clk),
    .num (dist2),
    .den ({1'b0, rad2}),
    .quo (ratio2)
  );

  always_ff @(posedge clk) begin : glow_chain
    logic [33:0] p1, p2, p3, p4;
    logic [32:0] p5, p6;
    p1 = 34'(g1_a) * 34'(g1_a);
    p2 = 34'(g2_a) * 34'(g2_a);
    p3 = 34'(gg1) * 34'(g1_b);
    p4 = 34'(gg2) * 34'(g2_b);
    p5 = 33'(g3_1) * 33'(ggpg_pkg::K1);
    p6 = 33'(g3_2) * 33'(ggpg_pkg::K2);

    g1_a  <= ggpg_pkg::Q_ONE - ratio1;
    g2_a  <= ggpg_pkg::Q_ONE - ratio2;
    gg1   <= p1[32:16];
    gg2   <= p2[32:16];
    g1_b  <= g1_a;
    g2_b  <= g2_a;
    g3_1  <= p3[32:16];
    g3_2  <= p4[32:16];
    glow1 <= p5[31:16];
    glow2 <= p6[31:16];
  end

  // A size of one gives a fraction of zero: feed the divider zero over one.
  assign fx_num = (w0 == dim_t'(1)) ? '0 : ggpg_pkg::div_opd_t'(x0);
  assign fx_den = (w0 == dim_t'(1)) ? ggpg_pkg::div_opd_t'(1)
                                    : ggpg_pkg::div_opd_t'(w0 - dim_t'(1));
  assign fy_num = (h0 == dim_t'(1)) ? '0 : ggpg_pkg::div_opd_t'(y0);
  assign fy_den = (h0 == dim_t'(1)) ? ggpg_pkg::div_opd_t'(1)
                                    : ggpg_pkg::div_opd_t'(h0 - dim_t'(1));

  ggpg_div u_div_fx (
    .clk (clk),
    .num (fx_num),
    .den (fx_den),
    .quo (fx)
  );

  ggpg_div u_div_fy (
    .clk (clk),
    .num (fy_num),
    .den (fy_den),
    .quo (fy)
  );

  always_ff @(posedge clk) begin
    top18.r <= lerp_q(ggpg_pkg::TL_R, ggpg_pkg::TR_R, fx);
    bot18.r <= lerp_q(ggpg_pkg::BL_R, ggpg_pkg::BR_R, fx);
    top18.g <= lerp_q(ggpg_pkg::TL_G, ggpg_pkg::TR_G, fx);
    bot18.g <= lerp_q(ggpg_pkg::BL_G, ggpg_pkg::BR_G, fx);
    top18.b <= lerp_q(ggpg_pkg::TL_B, ggpg_pkg::TR_B, fx);
    bot18.b <= lerp_q(ggpg_pkg::BL_B, ggpg_pkg::BR_B, fx);
    fy18    <= fy;

    a19     <= top18;
    up19[2] <= (bot18.r >= top18.r);
    up19[1] <= (bot18.g >= top18.g);
    up19[0] <= (bot18.b >= top18.b);
    mag19.r <= (bot18.r >= top18.r) ? bot18.r - top18.r : top18.r - bot18.r;
    mag19.g <= (bot18.g >= top18.g) ? bot18.g - top18.g : top18.g - bot18.g;
    mag19.b <= (bot18.b >= top18.b) ? bot18.b - top18.b : top18.b - bot18.b;
    fy19    <= fy18;

    base20.r <= lerp_fin(a19.r, mag19.r, up19[2], fy19);
    base20.g <= lerp_fin(a19.g, mag19.g, up19[1], fy19);
    base20.b <= lerp_fin(a19.b, mag19.b, up19[0], fy19);
  end

  // The base colour waits here for the glow chain to catch up.
  always_ff @(posedge clk) begin
    col_d[0] <= base20;
    for (int i = 1; i < COL_DELAY; i++) begin
      col_d[i] <= col_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    c55.r   <= add_glow(col_d[COL_DELAY-1].r, ggpg_pkg::HL1_R, glow1);
    c55.g   <= add_glow(col_d[COL_DELAY-1].g, ggpg_pkg::HL1_G, glow1);
    c55.b   <= add_glow(col_d[COL_DELAY-1].b, ggpg_pkg::HL1_B, glow1);
    glow2_d <= glow2;

    c56.r <= add_glow(c55.r, ggpg_pkg::HL2_R, glow2_d);
    c56.g <= add_glow(c55.g, ggpg_pkg::HL2_G, glow2_d);
    c56.b <= add_glow(c55.b, ggpg_pkg::HL2_B, glow2_d);

    pixel_argb <= {ggpg_pkg::ALPHA, to_byte(c56.r), to_byte(c56.g), to_byte(c56.b)};
  end

  `GGPG_ASSERT_IMPLIES(a_done_latency, clk, rst, done, $past(start, LAT), "done without a matching start")
  `GGPG_ASSERT_IMPLIES(a_radius_order, clk, rst, vld[DIST_STAGE], rad2 <= rad1, "second radius exceeds first")
  `GGPG_ASSERT_IMPLIES(a_glow_bound, clk, rst, vld[GLOW_STAGE], (glow1 <= ggpg_pkg::K1) && (glow2 <= ggpg_pkg::K2), "glow above its strength")

endmodule

`default_nettype wire
